/* src/clpd_pkg.sv */
// Shared codes, constants and chain control types for the char list block.
package clpd_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int REQ_W   = 3;
    localparam int VALUE_W = 8;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUSH      = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DUMP_FRNT = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DUMP_BACK = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ELEM  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;

    // what every cell does in a cycle
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_SHL,   // take the right neighbor (toward the front)
        OP_SHR    // take the left neighbor (toward the back)
    } t_cell_op;

    typedef struct packed {
        t_cell_op             op;
        logic                 cap_en;  // one addressed cell loads bcast instead
        logic [VALUE_W-1:0]   bcast;
    } t_cell_ctl;

endpackage

/* src/clpd_cell.sv */
// One storage cell of the entry chain: holds a byte, shifts or captures.
module clpd_cell #(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  logic                          i_clk,
    input  clpd_pkg::t_cell_ctl           i_ctl,
    input  logic [IDX_W-1:0]              i_cap_idx,
    input  logic [clpd_pkg::VALUE_W-1:0]  i_from_left,
    input  logic [clpd_pkg::VALUE_W-1:0]  i_from_right,
    output logic [clpd_pkg::VALUE_W-1:0]  o_data
);
    import clpd_pkg::*;

    logic [VALUE_W-1:0] r_data;
    logic [VALUE_W-1:0] n_data;

    always_comb begin
        if (i_ctl.cap_en && (i_cap_idx == IDX_W'(CELL_IDX))) begin
            n_data = i_ctl.bcast;
        end else begin
            unique case (i_ctl.op)
                OP_SHL:  n_data = i_from_right;
                OP_SHR:  n_data = i_from_left;
                default: n_data = r_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

/* src/clpd_chain.sv */
// Ring of DEPTH cells; cell 0 is the front, cell DEPTH-1 the back.
module clpd_chain #(
    parameter int DEPTH = clpd_pkg::DEPTH_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          i_clk,
    input  clpd_pkg::t_cell_ctl           i_ctl,
    input  logic [IDX_W-1:0]              i_cap_idx,
    output logic [clpd_pkg::VALUE_W-1:0]  o_head,
    output logic [clpd_pkg::VALUE_W-1:0]  o_tail
);
    import clpd_pkg::*;

    logic [VALUE_W-1:0] w_data [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        clpd_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (i_ctl),
            .i_cap_idx    (i_cap_idx),
            .i_from_left  (w_data[(g + DEPTH - 1) % DEPTH]),
            .i_from_right (w_data[(g + 1) % DEPTH]),
            .o_data       (w_data[g])
        );
    end

    assign o_head = w_data[0];
    assign o_tail = w_data[DEPTH-1];

endmodule

/* src/char_list_push_delete_dump.sv */
// Top level of the char list block: request sequencer around the cell chain.
// Ordered store of up to DEPTH bytes held in a ring of cells, front at cell 0.
// Request channel: a beat is taken at a rising edge with start high and busy
// low (req_type, item_value). Result channel: each result beat is shown for
// exactly one cycle with o_valid high; the receiver cannot stall it.
// Push: the chain shifts toward the back and cell 0 loads the byte;
//   one ack beat the cycle after the request (status full if no room).
// Clear and unknown requests: one ack beat.
// Delete: an empty store is acked at once. Each cycle the front byte leaves the
//   ring and, unless it matches, is written back at the live tail; the ack
//   beat follows the last step.
// Dump: a full rotation of the ring that leaves it as it was.
//   Front dump rotates toward the front and emits cell 0 while the rotation
//   step is below count; back dump rotates toward the back and emits cell
//   DEPTH-1 once the step reaches DEPTH-count. One beat per cycle, last marks
//   the final one. An empty store answers with one empty marker beat at once.
// Throughput: one request at a time; the next may start in the cycle the final
//   beat is shown, except that a front dump of fewer than DEPTH entries stays
//   busy until its rotation is done.
// Reset (synchronous, active low) empties the store; cell bytes are not
//   cleared and are never read beyond the count.
module char_list_push_delete_dump #(
    parameter int DEPTH = clpd_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [clpd_pkg::REQ_W-1:0]    i_req_type,
    input  logic [clpd_pkg::VALUE_W-1:0]  i_item_value,
    output logic                          o_valid,
    output logic [clpd_pkg::KIND_W-1:0]   o_result_kind,
    output logic [clpd_pkg::VALUE_W-1:0]  o_out_value,
    output logic [clpd_pkg::STAT_W-1:0]   o_status,
    output logic                          o_last
);
    import clpd_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEL,
        S_DUMP
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;     // live entries; shrinks during a delete
    logic [CNT_W-1:0]   r_rem;       // delete steps left
    logic [VALUE_W-1:0] r_val;       // byte being deleted
    logic               r_found;
    logic               r_back;      // dump direction
    logic [IDX_W-1:0]   r_step;      // rotation step of a dump

    logic               r_valid;
    logic [KIND_W-1:0]  r_kind;
    logic [VALUE_W-1:0] r_value;
    logic [STAT_W-1:0]  r_status;
    logic               r_last;

    t_cell_ctl          w_ctl;
    logic [IDX_W-1:0]   w_cap_idx;
    logic [VALUE_W-1:0] w_head;
    logic [VALUE_W-1:0] w_tail;

    logic               w_accept;
    logic               w_full;
    logic               w_keep;
    logic [CNT_W-1:0]   w_step_x;
    logic               w_step_end;
    logic               w_emit_f;
    logic               w_last_f;
    logic               w_emit_b;

    assign w_accept   = start && (r_state == S_IDLE);
    assign w_full     = (r_count >= CNT_W'(DEPTH));
    assign w_keep     = (w_head != r_val);
    assign w_step_x   = CNT_W'(r_step);
    assign w_step_end = (r_step == IDX_W'(DEPTH - 1));
    assign w_emit_f   = (w_step_x < r_count);
    assign w_last_f   = ((w_step_x + CNT_W'(1)) == r_count);
    assign w_emit_b   = (w_step_x >= (CNT_W'(DEPTH) - r_count));

    // chain control
    always_comb begin
        w_ctl.op     = OP_HOLD;
        w_ctl.cap_en = 1'b0;
        w_ctl.bcast  = w_head;
        w_cap_idx    = IDX_W'(r_count - CNT_W'(1));
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_req_type == REQ_PUSH) && !w_full) begin
                    w_ctl.op     = OP_SHR;
                    w_ctl.cap_en = 1'b1;
                    w_ctl.bcast  = i_item_value;
                    w_cap_idx    = '0;
                end
            end
            S_DEL: begin
                // front byte goes back in at the live tail if it survives
                w_ctl.op     = OP_SHL;
                w_ctl.cap_en = w_keep;
            end
            S_DUMP: begin
                w_ctl.op = r_back ? OP_SHR : OP_SHL;
            end
            default: ;
        endcase
    end

    clpd_chain #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_chain (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_cap_idx (w_cap_idx),
        .o_head    (w_head),
        .o_tail    (w_tail)
    );

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_kind   <= KIND_ACK;
                        r_value  <= '0;
                        r_status <= STAT_OK;
                        r_last   <= 1'b1;
                        r_val    <= i_item_value;
                        r_rem    <= r_count;
                        r_found  <= 1'b0;
                        r_step   <= '0;
                        r_back   <= (i_req_type == REQ_DUMP_BACK);
                        unique case (i_req_type)
                            REQ_PUSH: begin
                                r_valid <= 1'b1;
                                if (w_full) begin
                                    r_status <= STAT_FULL;
                                end else begin
                                    r_count <= r_count + CNT_W'(1);
                                end
                            end
                            REQ_DELETE: begin
                                if (r_count == '0) begin
                                    r_valid  <= 1'b1;
                                    r_status <= STAT_NOTFOUND;
                                end else begin
                                    r_state <= S_DEL;
                                end
                            end
                            REQ_DUMP_FRNT, REQ_DUMP_BACK: begin
                                if (r_count == '0) begin
                                    r_valid <= 1'b1;
                                    r_kind  <= KIND_EMPTY;
                                end else begin
                                    r_state <= S_DUMP;
                                end
                            end
                            REQ_CLEAR: begin
                                r_valid <= 1'b1;
                                r_count <= '0;
                            end
                            default: begin
                                r_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_DEL: begin
                    if (!w_keep) begin
                        r_count <= r_count - CNT_W'(1);
                        r_found <= 1'b1;
                    end
                    r_rem <= r_rem - CNT_W'(1);
                    if (r_rem == CNT_W'(1)) begin
                        r_valid  <= 1'b1;
                        r_kind   <= KIND_ACK;
                        r_value  <= '0;
                        r_status <= (r_found || !w_keep) ? STAT_OK : STAT_NOTFOUND;
                        r_last   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_DUMP: begin
                    r_kind   <= KIND_ELEM;
                    r_status <= STAT_OK;
                    if (r_back) begin
                        r_valid <= w_emit_b;
                        r_value <= w_tail;
                        r_last  <= w_step_end;
                    end else begin
                        r_valid <= w_emit_f;
                        r_value <= w_head;
                        r_last  <= w_last_f;
                    end
                    r_step <= r_step + IDX_W'(1);
                    if (w_step_end) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_result_kind = r_kind;
    assign o_out_value   = r_value;
    assign o_status      = r_status;
    assign o_last        = r_last;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req_type == REQ_PUSH) && !w_full)
        |=> (r_count == $past(r_count) + CNT_W'(1)) && o_valid && (o_status == STAT_OK))
        else $error("push did not add an entry");

    a_nonelem_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result_kind != KIND_ELEM)) |-> o_last)
        else $error("status or empty beat without last");

    a_del_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEL) |=> (r_count <= $past(r_count)))
        else $error("delete grew the store");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last && (r_state != S_IDLE)) |-> (r_state == S_DUMP) && !r_back)
        else $error("final beat while still busy");
`endif

endmodule
